// File: rtl/core/tcw_pkg.sv
// Shared constants and widths for the text console writer.
`timescale 1ns / 1ps

package tcw_pkg;

    localparam int COLUMNS_DEF     = 80;
    localparam int SCROLL_ROWS_DEF = 24;
    localparam int SCREEN_ROWS_DEF = 25;

    localparam int FUNC_W = 2;
    localparam int CHAR_W = 8;
    localparam int ADDR_W = 11;
    localparam int CELL_W = 16;
    localparam int ATTR_W = 8;

    localparam logic [FUNC_W-1:0] FUNC_PUT   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd2;

    localparam logic [CHAR_W-1:0] CHAR_BS    = 8'h08;
    localparam logic [CHAR_W-1:0] CHAR_LF    = 8'h0A;
    localparam logic [CHAR_W-1:0] CHAR_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;

    localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h07;

endpackage

// File: rtl/core/tcw_if.sv
// Item channels of the text console writer: command in, result out.
`timescale 1ns / 1ps

interface tcw_in_if;
    logic                       valid;
    logic                       ready;
    logic [tcw_pkg::FUNC_W-1:0] func;
    logic [tcw_pkg::CHAR_W-1:0] char_code;
    logic [tcw_pkg::ADDR_W-1:0] cell_address;

    modport source (output valid, func, char_code, cell_address, input ready);
    modport sink   (input valid, func, char_code, cell_address, output ready);
endinterface

interface tcw_out_if;
    logic                       valid;
    logic                       ready;
    logic [tcw_pkg::ADDR_W-1:0] cursor_pos;
    logic [tcw_pkg::CELL_W-1:0] cell_data;

    modport source (output valid, cursor_pos, cell_data, input ready);
    modport sink   (input valid, cursor_pos, cell_data, output ready);
endinterface

// File: rtl/core/text_console_writer_core.sv
// Text console writer: screen store in RAM, cursor tracking, scroll and clear sweeps.
// Steps: a plain put writes the character, then a blank at the new cursor; a read waits
// on the RAM; a clear sweeps the whole store; an unused code goes straight to the response
// step. A put that scrolls instead copies the text rows up one row, then clears the last text row.
// Throughput: one item at a time, the next taken from the cycle the result is presented.
// Reset: synchronous, active low; cursor homes, attribute becomes 0x07, then a sweep over all
// SCREEN_ROWS*COLUMNS cells zeroes the store, during which no item is accepted.
`timescale 1ns / 1ps

module text_console_writer_core #(
    parameter int COLUMNS     = tcw_pkg::COLUMNS_DEF,
    parameter int SCROLL_ROWS = tcw_pkg::SCROLL_ROWS_DEF,
    parameter int SCREEN_ROWS = tcw_pkg::SCREEN_ROWS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_wr_en,
    input  logic [tcw_pkg::ATTR_W-1:0] i_cfg_wr_data,
    tcw_in_if.sink                     i_in,
    tcw_out_if.source                  o_out
);

    localparam int CELLS     = SCREEN_ROWS * COLUMNS;
    localparam int SCROLL    = (SCROLL_ROWS < SCREEN_ROWS) ? SCROLL_ROWS : SCREEN_ROWS - 1;
    localparam int LIMIT     = SCROLL * COLUMNS;
    localparam int COPY_CNT  = (SCROLL - 1) * COLUMNS;
    localparam int AW        = $clog2(CELLS);
    localparam int RW        = $clog2(SCREEN_ROWS);
    localparam int CW        = $clog2(COLUMNS);

    typedef enum logic [3:0] {
        ST_SWEEP, ST_IDLE, ST_PUT, ST_COPY, ST_COPY_END, ST_CLEAR, ST_BLANK, ST_RD_WAIT,
        ST_RESP
    } t_state;

    t_state                     r_state;
    logic [AW-1:0]              r_idx;
    logic [AW-1:0]              r_cur;
    logic [RW-1:0]              r_row;
    logic [CW-1:0]              r_col;
    logic [tcw_pkg::ATTR_W-1:0] r_attr;
    logic [tcw_pkg::CHAR_W-1:0] r_char;
    logic                       r_rd_ok;
    logic                       r_cp_pend;
    logic [AW-1:0]              r_cp_addr;
    logic                       r_sweep_resp;
    logic [tcw_pkg::CELL_W-1:0] r_res_data;
    logic                       r_out_valid;
    logic [tcw_pkg::ADDR_W-1:0] r_out_cursor;
    logic [tcw_pkg::CELL_W-1:0] r_out_data;

    logic                       wr_en;
    logic [AW-1:0]              wr_addr;
    logic [tcw_pkg::CELL_W-1:0] wr_data;
    logic                       rd_en;
    logic [AW-1:0]              rd_addr;
    logic [tcw_pkg::CELL_W-1:0] rd_data;
    logic [tcw_pkg::CELL_W-1:0] blank_word;
    logic                       in_acc;
    logic                       out_free;
    logic [31:0]                cur_ext;

    logic [AW:0]                pos_pre;
    logic [RW:0]                row_pre;
    logic [CW-1:0]              col_pre;
    logic                       scroll;
    logic [AW-1:0]              n_cur;
    logic [RW-1:0]              n_row;

    tcw_ram #(
        .WIDTH (tcw_pkg::CELL_W),
        .DEPTH (CELLS)
    ) u_screen (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    assign blank_word = {r_attr, tcw_pkg::CHAR_SPACE};
    assign i_in.ready = (r_state == ST_IDLE);
    assign in_acc     = i_in.valid && i_in.ready;
    assign out_free   = !r_out_valid || o_out.ready;
    assign cur_ext    = 32'(r_cur);

    assign o_out.valid      = r_out_valid;
    assign o_out.cursor_pos = r_out_cursor;
    assign o_out.cell_data  = r_out_data;

    // Cursor after a put, before and after the scroll adjustment.
    always_comb begin
        pos_pre = {1'b0, r_cur};
        row_pre = {1'b0, r_row};
        col_pre = r_col;
        case (r_char) inside
            tcw_pkg::CHAR_LF, tcw_pkg::CHAR_CR: begin
                pos_pre = {1'b0, r_cur} - (AW+1)'(r_col) + (AW+1)'(COLUMNS);
                row_pre = {1'b0, r_row} + 1'b1;
                col_pre = '0;
            end
            tcw_pkg::CHAR_BS: begin
                if (r_cur != '0) begin
                    pos_pre = {1'b0, r_cur} - 1'b1;
                    if (r_col == '0) begin
                        row_pre = {1'b0, r_row} - 1'b1;
                        col_pre = CW'(COLUMNS - 1);
                    end else begin
                        col_pre = r_col - 1'b1;
                    end
                end
            end
            default: begin
                pos_pre = {1'b0, r_cur} + 1'b1;
                if (r_col == CW'(COLUMNS - 1)) begin
                    row_pre = {1'b0, r_row} + 1'b1;
                    col_pre = '0;
                end else begin
                    col_pre = r_col + 1'b1;
                end
            end
        endcase
        scroll = (row_pre >= (RW+1)'(SCROLL));
        n_cur  = scroll ? AW'(pos_pre - (AW+1)'(COLUMNS)) : AW'(pos_pre);
        n_row  = scroll ? RW'(row_pre - 1'b1) : RW'(row_pre);
    end

    // RAM port selection by state.
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_idx;
        wr_data = '0;
        rd_en   = 1'b0;
        rd_addr = AW'(r_idx + AW'(COLUMNS));
        unique case (r_state)
            ST_SWEEP: begin
                wr_en = 1'b1;
            end
            ST_IDLE: begin
                rd_en   = in_acc && (i_in.func == tcw_pkg::FUNC_READ);
                rd_addr = AW'(i_in.cell_address);
            end
            ST_PUT: begin
                wr_en   = (r_char != tcw_pkg::CHAR_LF) && (r_char != tcw_pkg::CHAR_CR)
                          && (r_char != tcw_pkg::CHAR_BS);
                wr_addr = r_cur;
                wr_data = {r_attr, r_char};
            end
            ST_COPY: begin
                rd_en   = 1'b1;
                wr_en   = r_cp_pend;
                wr_addr = r_cp_addr;
                wr_data = rd_data;
            end
            ST_COPY_END: begin
                wr_en   = r_cp_pend;
                wr_addr = r_cp_addr;
                wr_data = rd_data;
            end
            ST_CLEAR: begin
                wr_en   = 1'b1;
                wr_data = (r_idx == r_cur) ? blank_word : '0;
            end
            ST_BLANK: begin
                wr_en   = 1'b1;
                wr_addr = r_cur;
                wr_data = blank_word;
            end
            ST_RD_WAIT, ST_RESP: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_SWEEP;
            r_idx        <= '0;
            r_cur        <= '0;
            r_row        <= '0;
            r_col        <= '0;
            r_attr       <= tcw_pkg::ATTR_RESET;
            r_cp_pend    <= 1'b0;
            r_sweep_resp <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_attr <= i_cfg_wr_data;
            end
            // raise on the response step, drop once the item is taken
            r_out_valid <= ((r_state == ST_RESP) && out_free) || (r_out_valid && !o_out.ready);
            r_cp_pend <= (r_state == ST_COPY);
            r_cp_addr <= r_idx;

            unique case (r_state)
                ST_SWEEP: begin
                    if (r_idx == AW'(CELLS - 1)) begin
                        r_idx   <= '0;
                        r_state <= r_sweep_resp ? ST_RESP : ST_IDLE;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                ST_IDLE: begin
                    if (in_acc) begin
                        r_char     <= i_in.char_code;
                        r_res_data <= '0;
                        r_rd_ok    <= (32'(i_in.cell_address) < 32'(CELLS));
                        case (i_in.func)
                            tcw_pkg::FUNC_PUT:   r_state <= ST_PUT;
                            tcw_pkg::FUNC_READ:  r_state <= ST_RD_WAIT;
                            tcw_pkg::FUNC_CLEAR: begin
                                r_cur        <= '0;
                                r_row        <= '0;
                                r_col        <= '0;
                                r_idx        <= '0;
                                r_sweep_resp <= 1'b1;
                                r_state      <= ST_SWEEP;
                            end
                            default: r_state <= ST_RESP;
                        endcase
                    end
                end
                ST_PUT: begin
                    r_cur   <= n_cur;
                    r_row   <= n_row;
                    r_col   <= col_pre;
                    r_idx   <= '0;
                    r_state <= scroll ? ST_COPY : ST_BLANK;
                end
                ST_COPY: begin
                    // read one row ahead, write the word back a row up next cycle
                    if (r_idx == AW'(COPY_CNT - 1)) begin
                        r_idx   <= r_cur;
                        r_state <= ST_COPY_END;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                ST_COPY_END: begin
                    r_state <= ST_CLEAR;
                end
                ST_CLEAR: begin
                    if (r_idx == AW'(LIMIT - 1)) begin
                        r_state <= ST_RESP;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                ST_BLANK: begin
                    r_state <= ST_RESP;
                end
                ST_RD_WAIT: begin
                    r_res_data <= r_rd_ok ? rd_data : '0;
                    r_state    <= ST_RESP;
                end
                ST_RESP: begin
                    if (out_free) begin
                        r_out_cursor <= cur_ext[tcw_pkg::ADDR_W-1:0];
                        r_out_data   <= r_res_data;
                        r_sweep_resp <= 1'b0;
                        r_state      <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // Row and column track the linear cursor, which stays above the scroll row.
    a_cursor_consistent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (32'(r_cur) == 32'(r_row) * COLUMNS + 32'(r_col)) && (32'(r_cur) < LIMIT))
        else $error("cursor row/column out of step with linear cursor");

    a_one_item_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> !i_in.ready)
        else $error("second item accepted while one is in flight");

    a_result_from_resp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == ST_RESP))
        else $error("result presented outside the response step");

    a_copy_write_behind_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_COPY && r_cp_pend) |-> (32'(rd_addr) == 32'(r_cp_addr) + COLUMNS + 1))
        else $error("scroll copy write overtook its read");

endmodule

// File: rtl/core/tcw_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: verif/text_console_writer_core_tb.sv
// Self-checking testbench for the text console writer: directed rows, then random traffic.
`timescale 1ns / 1ps

module text_console_writer_core_tb;

    localparam int COLS       = tcw_pkg::COLUMNS_DEF;
    localparam int ROWS       = tcw_pkg::SCREEN_ROWS_DEF;
    localparam int SCROLL_EFF = (tcw_pkg::SCROLL_ROWS_DEF < ROWS) ? tcw_pkg::SCROLL_ROWS_DEF
                                                                   : ROWS - 1;
    localparam int CELLS      = ROWS * COLS;
    localparam int FW         = tcw_pkg::FUNC_W;
    localparam int CHW        = tcw_pkg::CHAR_W;
    localparam int AW         = tcw_pkg::ADDR_W;
    localparam int DW         = tcw_pkg::CELL_W;
    localparam int ATW        = tcw_pkg::ATTR_W;

    localparam logic [FW-1:0] FUNC_NONE = 2'd3;

    localparam int PHASE_ITEMS = 250;
    localparam int MAX_PRINTS  = 100;

    typedef struct packed {
        logic [AW-1:0] cursor_pos;
        logic [DW-1:0] cell_data;
    } t_console_result;

    typedef enum logic {ROW_ITEM, ROW_CFG} t_row_kind;

    typedef struct packed {
        t_row_kind      kind;
        logic [FW-1:0]  func;
        logic [CHW-1:0] char_code;
        logic [AW-1:0]  cell_address;
        logic [7:0]     reps;
        logic           typed;
        logic [AW-1:0]  exp_cursor;
        logic [DW-1:0]  exp_data;
    } t_stim_row;

    localparam int DIRECTED_ROWS = 27;

    // For config rows the char_code field carries the attribute value.
    t_stim_row directed_rows [DIRECTED_ROWS] = '{
        '{ROW_ITEM, tcw_pkg::FUNC_READ,  8'h00, 11'd0,    8'd1, 1'b1, 11'd0, 16'h0000},
        '{ROW_ITEM, tcw_pkg::FUNC_READ,  8'h00, 11'd1999, 8'd1, 1'b1, 11'd0, 16'h0000},
        '{ROW_ITEM, tcw_pkg::FUNC_READ,  8'hFF, 11'd2047, 8'd1, 1'b1, 11'd0, 16'h0000},
        '{ROW_ITEM, FUNC_NONE,           8'hFF, 11'd2047, 8'd1, 1'b1, 11'd0, 16'h0000},
        '{ROW_ITEM, tcw_pkg::FUNC_PUT,   8'h41, 11'd0,    8'd1, 1'b1, 11'd1, 16'h0000},
        '{ROW_ITEM, tcw_pkg::FUNC_READ,  8'h00, 11'd0,    8'd1, 1'b1, 11'd1, 16'h0741},
        '{ROW_ITEM, tcw_pkg::FUNC_READ,  8'h00, 11'd1,    8'd1, 1'b1, 11'd1, 16'h0720},
        '{ROW_ITEM, tcw_pkg::FUNC_PUT, tcw_pkg::CHAR_BS, 11'd0, 8'd1, 1'b1, 11'd0, 16'h0000},
        '{ROW_ITEM, tcw_pkg::FUNC_PUT, tcw_pkg::CHAR_BS, 11'd0, 8'd1, 1'b1, 11'd0, 16'h0000},
        '{ROW_ITEM, tcw_pkg::FUNC_PUT,   8'h00, 11'd0,    8'd1, 1'b1, 11'd1, 16'h0000},
        '{ROW_ITEM, tcw_pkg::FUNC_PUT,   8'hFF, 11'd0,    8'd1, 1'b1, 11'd2, 16'h0000},
        '{ROW_ITEM, tcw_pkg::FUNC_READ,  8'h00, 11'd1,    8'd1, 1'b1, 11'd2, 16'h07FF},
        '{ROW_ITEM, tcw_pkg::FUNC_PUT, tcw_pkg::CHAR_CR, 11'd0, 8'd1, 1'b1, 11'd80, 16'h0000},
        '{ROW_ITEM, tcw_pkg::FUNC_PUT, tcw_pkg::CHAR_LF, 11'd0, 8'd1, 1'b1, 11'd160, 16'h0000},
        '{ROW_ITEM, tcw_pkg::FUNC_CLEAR, 8'h00, 11'd0,    8'd1, 1'b1, 11'd0, 16'h0000},
        '{ROW_ITEM, tcw_pkg::FUNC_READ,  8'h00, 11'd1,    8'd1, 1'b1, 11'd0, 16'h0000},
        '{ROW_CFG,  tcw_pkg::FUNC_PUT,   8'hFF, 11'd0,    8'd1, 1'b0, 11'd0, 16'h0000},
        '{ROW_ITEM, tcw_pkg::FUNC_PUT, tcw_pkg::CHAR_LF, 11'd0, 8'd1, 1'b1, 11'd80, 16'h0000},
        '{ROW_ITEM, tcw_pkg::FUNC_PUT,   8'h51, 11'd0,    8'd1, 1'b1, 11'd81, 16'h0000},
        '{ROW_ITEM, tcw_pkg::FUNC_PUT, tcw_pkg::CHAR_LF, 11'd0, 8'd22, 1'b0, 11'd0, 16'h0000},
        '{ROW_ITEM, tcw_pkg::FUNC_PUT,   8'h7E, 11'd0,    8'd1, 1'b0, 11'd0, 16'h0000},
        // newline on the last text row: scroll up one row
        '{ROW_ITEM, tcw_pkg::FUNC_PUT, tcw_pkg::CHAR_LF, 11'd0, 8'd1, 1'b0, 11'd0, 16'h0000},
        '{ROW_ITEM, tcw_pkg::FUNC_READ,  8'h00, 11'd0,    8'd1, 1'b0, 11'd0, 16'h0000},
        '{ROW_ITEM, tcw_pkg::FUNC_READ,  8'h00, 11'd1760, 8'd1, 1'b0, 11'd0, 16'h0000},
        '{ROW_CFG,  tcw_pkg::FUNC_PUT,   8'h00, 11'd0,    8'd1, 1'b0, 11'd0, 16'h0000},
        '{ROW_ITEM, tcw_pkg::FUNC_PUT,   8'h78, 11'd0,    8'd1, 1'b0, 11'd0, 16'h0000},
        '{ROW_ITEM, tcw_pkg::FUNC_READ,  8'h00, 11'd1840, 8'd1, 1'b0, 11'd0, 16'h0000}
    };

    logic           i_clk;
    logic           i_rst_n;
    logic           i_cfg_wr_en;
    logic [ATW-1:0] i_cfg_wr_data;

    tcw_in_if  cmd_if ();
    tcw_out_if res_if ();

    text_console_writer_core u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in          (cmd_if),
        .o_out         (res_if)
    );

    // Predictor state
    logic [DW-1:0]  screen_model [CELLS];
    int unsigned    cursor_model;
    logic [ATW-1:0] attr_model;

    t_console_result pending_results [$];
    int              error_count;
    bit              steady_flow;

    initial i_clk = 1'b0;
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    initial begin
        #20_000_000;
        $display("Some tests failed");
        $finish;
    end

    task automatic flag_error(input string msg);
        if (error_count < MAX_PRINTS)
            $display("ERROR @%0t: %s", $time, msg);
        error_count++;
    endtask

    function automatic t_console_result predict_command(input logic [FW-1:0]  f,
                                                        input logic [CHW-1:0] c,
                                                        input logic [AW-1:0]  a);
        t_console_result res;
        int unsigned     pos;
        logic [DW-1:0]   attr_word;
        res.cell_data = '0;
        attr_word     = {attr_model, 8'h00};
        case (f)
            tcw_pkg::FUNC_PUT: begin
                pos = cursor_model;
                if (c == tcw_pkg::CHAR_LF || c == tcw_pkg::CHAR_CR) begin
                    pos += COLS - (pos % COLS);
                end else if (c == tcw_pkg::CHAR_BS) begin
                    if (pos > 0)
                        pos--;
                end else begin
                    if (pos < CELLS)
                        screen_model[pos] = attr_word | DW'(c);
                    pos++;
                end
                if (pos / COLS >= SCROLL_EFF) begin
                    // move rows up, then wipe from the cursor to the end of the text area
                    for (int i = 0; i < (SCROLL_EFF - 1) * COLS; i++)
                        screen_model[i] = screen_model[i + COLS];
                    pos -= COLS;
                    for (int i = int'(pos); i < SCROLL_EFF * COLS; i++)
                        screen_model[i] = '0;
                end
                if (pos >= CELLS)
                    pos = 0;
                cursor_model      = pos;
                screen_model[pos] = attr_word | DW'(tcw_pkg::CHAR_SPACE);
            end
            tcw_pkg::FUNC_READ: begin
                if (a < CELLS)
                    res.cell_data = screen_model[a];
            end
            tcw_pkg::FUNC_CLEAR: begin
                for (int i = 0; i < CELLS; i++)
                    screen_model[i] = '0;
                cursor_model = 0;
            end
            default: ;
        endcase
        res.cursor_pos = cursor_model[AW-1:0];
        return res;
    endfunction

    // Called at a falling edge; returns at the falling edge after the item is taken.
    task automatic issue_command(input logic [FW-1:0] f, input logic [CHW-1:0] c,
                                 input logic [AW-1:0] a, input bit use_typed,
                                 input t_console_result typed_res);
        t_console_result predicted;
        if (!steady_flow && $urandom_range(99) < 24) begin
            cmd_if.valid = 1'b0;
            repeat ($urandom_range(4, 1)) @(negedge i_clk);
        end
        cmd_if.valid        = 1'b1;
        cmd_if.func         = f;
        cmd_if.char_code    = c;
        cmd_if.cell_address = a;
        @(posedge i_clk);
        while (!cmd_if.ready)
            @(posedge i_clk);
        predicted = predict_command(f, c, a);
        pending_results.push_back(use_typed ? typed_res : predicted);
        @(negedge i_clk);
    endtask

    task automatic wait_idle(input int tail);
        cmd_if.valid = 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (tail) @(negedge i_clk);
    endtask

    task automatic write_attribute(input logic [ATW-1:0] value);
        wait_idle(4);
        i_cfg_wr_en   = 1'b1;
        i_cfg_wr_data = value;
        @(negedge i_clk);
        i_cfg_wr_en = 1'b0;
        attr_model  = value;
    endtask

    initial begin
        res_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            res_if.ready <= steady_flow || ($urandom_range(99) >= 24);
        end
    end

    always @(posedge i_clk) begin : check_results
        t_console_result want;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (pending_results.size() == 0) begin
                flag_error("result item with nothing pending");
            end else begin
                want = pending_results.pop_front();
                if (res_if.cursor_pos !== want.cursor_pos)
                    flag_error($sformatf("cursor_pos %0d, want %0d",
                                         res_if.cursor_pos, want.cursor_pos));
                if (res_if.cell_data !== want.cell_data)
                    flag_error($sformatf("cell_data 0x%04h, want 0x%04h",
                                         res_if.cell_data, want.cell_data));
            end
        end
    end

    initial begin
        logic [FW-1:0]   f;
        logic [CHW-1:0]  c;
        logic [AW-1:0]   a;
        int unsigned     pick;
        logic [ATW-1:0]  phase_attr;
        t_console_result typed_res;

        error_count         = 0;
        steady_flow         = 1'b0;
        i_rst_n             = 1'b0;
        i_cfg_wr_en         = 1'b0;
        i_cfg_wr_data       = '0;
        cmd_if.valid        = 1'b0;
        cmd_if.func         = tcw_pkg::FUNC_PUT;
        cmd_if.char_code    = '0;
        cmd_if.cell_address = '0;
        for (int i = 0; i < CELLS; i++)
            screen_model[i] = '0;
        cursor_model = 0;
        attr_model   = tcw_pkg::ATTR_RESET;

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (directed_rows[r]) begin
            if (directed_rows[r].kind == ROW_CFG) begin
                write_attribute(directed_rows[r].char_code);
            end else begin
                typed_res.cursor_pos = directed_rows[r].exp_cursor;
                typed_res.cell_data  = directed_rows[r].exp_data;
                repeat (directed_rows[r].reps)
                    issue_command(directed_rows[r].func, directed_rows[r].char_code,
                                  directed_rows[r].cell_address, directed_rows[r].typed,
                                  typed_res);
            end
        end

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                1:       phase_attr = 8'hFF;
                2:       phase_attr = 8'h00;
                default: phase_attr = ATW'($urandom_range(255));
            endcase
            write_attribute(phase_attr);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                steady_flow = (phase == 1) && (n >= 40) && (n < 200);
                pick = $urandom_range(99);
                if (pick < 84)
                    f = tcw_pkg::FUNC_PUT;
                else if (pick < 96)
                    f = tcw_pkg::FUNC_READ;
                else if (pick < 97)
                    f = tcw_pkg::FUNC_CLEAR;
                else
                    f = FUNC_NONE;
                pick = $urandom_range(99);
                if (pick < 4)
                    c = tcw_pkg::CHAR_LF;
                else if (pick < 8)
                    c = tcw_pkg::CHAR_CR;
                else if (pick < 13)
                    c = tcw_pkg::CHAR_BS;
                else
                    c = CHW'($urandom_range(255));
                // half the reads land just behind the cursor, where text was written
                if ($urandom_range(1))
                    a = AW'($urandom_range(2047));
                else
                    a = AW'((cursor_model + CELLS - $urandom_range(160)) % CELLS);
                issue_command(f, c, a, 1'b0, '0);
            end
        end
        steady_flow = 1'b0;

        wait_idle(16);
        if (error_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
